@@ rtl/scpi_header_recognizer_assert.svh @@
// Assertion macros for the SCPI header recogniser checker.
// Needs a clk and an active-low rst_n in the including scope.
`ifndef SCPI_HEADER_RECOGNIZER_ASSERT_SVH
`define SCPI_HEADER_RECOGNIZER_ASSERT_SVH

// same-cycle implication, muted during reset
`define SCPI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scpi header recogniser: assertion failed");

// next-cycle implication, muted during reset
`define SCPI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scpi header recogniser: assertion failed");

`endif

@@ rtl/scpi_hdr_pkg.sv @@
// Shared types, character codes and the keyword ROM for the SCPI header recogniser.
// No dependencies.
`default_nettype none

package scpi_hdr_pkg;

    localparam int KEYWORD_COUNT_DEF = 19;
    localparam int KW_SLOTS          = 32;
    localparam int KW_POS            = 9;   // usable characters per keyword

    typedef enum logic [1:0] {
        KIND_CMD = 2'd0,
        KIND_ERR = 2'd1,
        KIND_ARG = 2'd2,
        KIND_EOL = 2'd3
    } kind_t;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // keywords left-justified, first character in the top byte, zero padded
    localparam logic [8*KW_POS-1:0] KW_ROM [KW_SLOTS] = '{
        0:  {"*IDN ?",    24'h0},
        1:  {"*IDN?",     32'h0},
        2:  {"RUN",       48'h0},
        3:  {"STOP",      40'h0},
        4:  {"*RST",      40'h0},
        5:  {"AUTOSCALE"},
        6:  {"REQUEST ?"},
        7:  {"DISPLAY",   16'h0},
        8:  {"DISP",      40'h0},
        9:  {"CHANNEL1",   8'h0},
        10: {"CHAN1",     32'h0},
        11: {"CHANNEL2",   8'h0},
        12: {"CHAN2",     32'h0},
        13: {"TRIGGER",   16'h0},
        14: {"TRIG",      40'h0},
        15: {"TBASE",     32'h0},
        16: {"TBAS",      40'h0},
        17: {"KEY",       48'h0},
        18: {"GOVERNOR",   8'h0},
        default: '0
    };

    function automatic logic [7:0] kw_char(input logic [4:0] slot, input logic [3:0] pos);
        logic [8*KW_POS-1:0] word;
        logic [7:0]          ch;
        word = KW_ROM[slot];
        ch   = 8'h00;
        for (int p = 0; p < KW_POS; p++)
        begin
            if (pos == 4'(p))
            begin
                ch = word[8*(KW_POS-p)-1 -: 8];
            end
        end
        return ch;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    function automatic logic is_line_end(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

`default_nettype wire

@@ rtl/scpi_hdr_if.sv @@
// Valid/ready channel interfaces: command bytes in, recogniser results out.
// Uses scpi_hdr_pkg for the result kind type.
`default_nettype none

interface scpi_hdr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface scpi_hdr_out_if;
    logic                valid;
    logic                ready;
    scpi_hdr_pkg::kind_t kind;
    logic [4:0]          command_index;
    logic [7:0]          arg_byte;

    modport source (output valid, output kind, output command_index, output arg_byte,
                    input ready);
    modport sink   (input valid, input kind, input command_index, input arg_byte,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/scpi_hdr_kw_match.sv @@
// Keyword ROM compare: narrows the live set by one character and finds the
// lowest live entry. Depends on scpi_hdr_pkg.
`default_nettype none

module scpi_hdr_kw_match #(
    parameter int KEYWORD_COUNT = scpi_hdr_pkg::KEYWORD_COUNT_DEF
) (
    input  wire logic [KEYWORD_COUNT-1:0] live_src,
    input  wire logic [3:0]               pos,
    input  wire logic [7:0]               ch,
    output logic      [KEYWORD_COUNT-1:0] live_filt,
    input  wire logic [KEYWORD_COUNT-1:0] live_cur,
    output logic                          found,
    output logic      [4:0]               index
);

    logic [7:0] rom_ch [KEYWORD_COUNT];

    always_comb
    begin
        for (int k = 0; k < KEYWORD_COUNT; k++)
        begin
            rom_ch[k]    = scpi_hdr_pkg::kw_char(5'(k), pos);
            live_filt[k] = live_src[k] && (rom_ch[k] != 8'h00) && (rom_ch[k] == ch);
        end
    end

    // lowest set bit wins
    always_comb
    begin
        found = |live_cur;
        index = 5'd0;
        for (int k = KEYWORD_COUNT - 1; k >= 0; k--)
        begin
            if (live_cur[k])
            begin
                index = 5'(k);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/scpi_header_recognizer.sv @@
// SCPI header recogniser: each accepted beat passes the input register, then the result register.
// Throughput: one byte per cycle while the result side takes beats; the input register and the
// result register each hold one beat, so a stalled result blocks at most two bytes upstream.
// A byte in the input register fires once the result register is free; its result (if any) is registered then.
// Reset (rst_n, asynchronous, active low): phase back to separator skipping, all keywords live,
// header length zero, both pipeline registers empty.
`default_nettype none

module scpi_header_recognizer #(
    parameter int KEYWORD_COUNT = scpi_hdr_pkg::KEYWORD_COUNT_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    scpi_hdr_in_if.sink     cmd,
    scpi_hdr_out_if.source  res
);

    typedef enum logic [1:0] {
        PH_SKIP    = 2'd0,   // eating leading ':', CR, LF
        PH_HEADER  = 2'd1,   // collecting header characters
        PH_ARGS    = 2'd2,   // passing argument bytes
        PH_DISCARD = 2'd3    // dropping the rest of a bad line
    } phase_t;

    localparam logic [KEYWORD_COUNT-1:0] ALL_LIVE = {KEYWORD_COUNT{1'b1}};

    // input register stage
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg,  s1_byte_next;

    // parser state
    phase_t                   phase_reg,  phase_next;
    logic [KEYWORD_COUNT-1:0] live_reg,   live_next;
    logic [3:0]               len_reg,    len_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    scpi_hdr_pkg::kind_t kind_reg,      kind_next;
    logic [4:0]          index_reg,     index_next;
    logic [7:0]          arg_reg,       arg_next;

    logic                     out_free;
    logic                     s1_fire;
    logic [7:0]               c;
    logic                     is_term;
    logic                     emit;
    scpi_hdr_pkg::kind_t      emit_kind;
    logic [4:0]               emit_index;
    logic [7:0]               emit_arg;
    logic [KEYWORD_COUNT-1:0] live_src;
    logic [3:0]               pos;
    logic [KEYWORD_COUNT-1:0] live_filt;
    logic                     found;
    logic [4:0]               found_index;

    // result register frees up when empty or drained this cycle
    assign out_free  = !out_valid_reg || res.ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign cmd.ready = !s1_valid_reg || s1_fire;

    assign c       = scpi_hdr_pkg::to_upper(s1_byte_reg);
    assign is_term = (c == scpi_hdr_pkg::CH_COLON) || (c == scpi_hdr_pkg::CH_SPACE) ||
                     scpi_hdr_pkg::is_line_end(c);

    // first header character always compares against the full ROM at position zero
    assign live_src = (phase_reg == PH_SKIP) ? ALL_LIVE : live_reg;
    assign pos      = (phase_reg == PH_SKIP) ? 4'd0 : len_reg;

    scpi_hdr_kw_match #(
        .KEYWORD_COUNT (KEYWORD_COUNT)
    ) u_kw_match (
        .live_src  (live_src),
        .pos       (pos),
        .ch        (c),
        .live_filt (live_filt),
        .live_cur  (live_reg),
        .found     (found),
        .index     (found_index)
    );

    always_comb
    begin
        phase_next = phase_reg;
        live_next  = live_reg;
        len_next   = len_reg;
        emit       = 1'b0;
        emit_kind  = scpi_hdr_pkg::KIND_CMD;
        emit_index = 5'd0;
        emit_arg   = 8'h00;

        unique case (phase_reg)
            PH_SKIP:
            begin
                if (c == scpi_hdr_pkg::CH_SPACE)
                begin
                    // empty header: line dropped silently
                    phase_next = PH_DISCARD;
                end
                else if (!is_term)
                begin
                    live_next  = live_filt;
                    len_next   = 4'd1;
                    phase_next = PH_HEADER;
                end
            end
            PH_HEADER:
            begin
                if (is_term)
                begin
                    emit = 1'b1;
                    if (found)
                    begin
                        emit_kind  = scpi_hdr_pkg::KIND_CMD;
                        emit_index = found_index;
                    end
                    else
                    begin
                        emit_kind = scpi_hdr_pkg::KIND_ERR;
                    end
                    // CR/LF closes the line with no separate line-end beat
                    if (scpi_hdr_pkg::is_line_end(c))
                    begin
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = found ? PH_ARGS : PH_DISCARD;
                    end
                    live_next = ALL_LIVE;
                    len_next  = 4'd0;
                end
                else
                begin
                    live_next = live_filt;
                    if (len_reg != 4'd15)
                    begin
                        len_next = len_reg + 4'd1;
                    end
                end
            end
            PH_ARGS:
            begin
                emit = 1'b1;
                if (scpi_hdr_pkg::is_line_end(c))
                begin
                    emit_kind  = scpi_hdr_pkg::KIND_EOL;
                    phase_next = PH_SKIP;
                end
                else
                begin
                    emit_kind = scpi_hdr_pkg::KIND_ARG;
                    emit_arg  = c;
                end
            end
            PH_DISCARD:
            begin
                if (scpi_hdr_pkg::is_line_end(c))
                begin
                    phase_next = PH_SKIP;
                end
            end
            default:
            begin
                phase_next = PH_SKIP;
            end
        endcase

        if (!s1_fire)
        begin
            phase_next = phase_reg;
            live_next  = live_reg;
            len_next   = len_reg;
        end
    end

    always_comb
    begin
        s1_byte_next  = s1_byte_reg;
        s1_valid_next = s1_valid_reg;
        if (cmd.valid && cmd.ready)
        begin
            s1_valid_next = 1'b1;
            s1_byte_next  = cmd.in_byte;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        index_next     = index_reg;
        arg_next       = arg_reg;
        if (s1_fire)
        begin
            out_valid_next = emit;
            if (emit)
            begin
                kind_next  = emit_kind;
                index_next = emit_index;
                arg_next   = emit_arg;
            end
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            phase_reg     <= PH_SKIP;
            live_reg      <= ALL_LIVE;
            len_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            phase_reg     <= phase_next;
            live_reg      <= live_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        s1_byte_reg <= s1_byte_next;
        kind_reg    <= kind_next;
        index_reg   <= index_next;
        arg_reg     <= arg_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.kind          = kind_reg;
    assign res.command_index = index_reg;
    assign res.arg_byte      = arg_reg;

endmodule

`default_nettype wire

@@ rtl/scpi_hdr_checker.sv @@
// Port-level checker for the SCPI header recogniser, bound to the top level.
// Depends on scpi_hdr_pkg and scpi_header_recognizer_assert.svh.
`default_nettype none

`include "scpi_header_recognizer_assert.svh"

module scpi_hdr_checker #(
    parameter int KEYWORD_COUNT = scpi_hdr_pkg::KEYWORD_COUNT_DEF
) (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [1:0] res_kind,
    input wire logic [4:0] res_index,
    input wire logic [7:0] res_arg
);

    localparam int ROM_USED = (KEYWORD_COUNT < scpi_hdr_pkg::KEYWORD_COUNT_DEF) ?
                              KEYWORD_COUNT : scpi_hdr_pkg::KEYWORD_COUNT_DEF;

    // a stalled result beat holds
    `SCPI_ASSERT_NEXT(a_res_hold, res_valid && !res_ready,
        res_valid && $stable(res_kind) && $stable(res_index) && $stable(res_arg))

    // index only on a recognised command, and only a populated ROM entry
    `SCPI_ASSERT_NOW(a_index_range, res_valid,
        (res_kind == scpi_hdr_pkg::KIND_CMD) ? (32'(res_index) < ROM_USED) : (res_index == 5'd0))

    // argument bytes never carry lowercase letters or line ends; other kinds carry zero
    `SCPI_ASSERT_NOW(a_arg_clean, res_valid,
        (res_kind == scpi_hdr_pkg::KIND_ARG) ?
            (!(res_arg >= 8'h61 && res_arg <= 8'h7A) && res_arg != scpi_hdr_pkg::CH_CR &&
             res_arg != scpi_hdr_pkg::CH_LF) :
            (res_arg == 8'h00))

    // two line-end beats never come back to back: a new header must be recognised
    // in between
    `SCPI_ASSERT_NOW(a_no_back_to_back_eol, res_valid && res_ready &&
        res_kind == scpi_hdr_pkg::KIND_EOL,
        1'b1 && !($past(res_valid && res_ready) && $past(res_kind) == scpi_hdr_pkg::KIND_EOL))

endmodule

bind scpi_header_recognizer scpi_hdr_checker #(
    .KEYWORD_COUNT (KEYWORD_COUNT)
) u_scpi_hdr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_kind  (res.kind),
    .res_index (res.command_index),
    .res_arg   (res.arg_byte)
);

`default_nettype wire

@@ dv/tb_scpi_header_recognizer.sv @@
// Self-checking testbench for scpi_header_recognizer: directed table, then random command lines.
// Depends on scpi_hdr_pkg (result kind, character codes), scpi_hdr_if.sv and the RTL top.
// Every result beat is checked in order against its booked expectation: predicted, or typed in the directed table.
`default_nettype none

module tb_scpi_header_recognizer;
    timeunit 1ns;
    timeprecision 1ps;

    import scpi_hdr_pkg::*;

    localparam int KEYWORDS       = 19;
    localparam int ITEM_TARGET    = 1850;
    localparam int QUIET_TAIL     = 150;   // final stretch with no idling on either side
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either channel
    localparam int DRAIN_CYCLES   = 8;     // extra wait after every booked result beat has come back

    // One result beat as the block presents it.
    typedef struct packed {
        kind_t      kind;
        logic [4:0] command_index;
        logic [7:0] arg_byte;
    } hdr_result_t;

    // Where the recogniser stands within the current line.
    typedef enum logic [1:0] {
        LP_SKIP    = 2'd0,
        LP_HEADER  = 2'd1,
        LP_ARGS    = 2'd2,
        LP_DISCARD = 2'd3
    } line_phase_t;

    // How a stimulus row gets its expectation.
    typedef enum logic [1:0] {
        CHECK_PREDICTED,  // whatever the predictor says
        CHECK_SILENT,     // typed: no result
        CHECK_TYPED       // typed: exactly the result in the row
    } check_mode_t;

    typedef struct {
        logic [7:0]  ch;
        check_mode_t check;
        kind_t       kind;
        logic [4:0]  index;
        logic [7:0]  arg;
    } stim_row_t;

    // Keyword table, lowest index wins on a prefix match.
    string keyword_text [KEYWORDS] = '{
        "*IDN ?", "*IDN?", "RUN", "STOP", "*RST", "AUTOSCALE", "REQUEST ?",
        "DISPLAY", "DISP", "CHANNEL1", "CHAN1", "CHANNEL2", "CHAN2",
        "TRIGGER", "TRIG", "TBASE", "TBAS", "KEY", "GOVERNOR"
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    scpi_hdr_in_if  cmd_if ();
    scpi_hdr_out_if res_if ();

    scpi_header_recognizer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    // Predictor state: mirrors the block's line phase, live keyword set and header length.
    line_phase_t         lp_phase   = LP_SKIP;
    logic [KEYWORDS-1:0] live_set   = '1;
    logic [3:0]          header_len = 4'd0;

    hdr_result_t pending_results [$];  // expected result beats, oldest first

    int fail_count  = 0;
    int bytes_sent  = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    bit gaps_on     = 1'b0;
    bit stalls_on   = 1'b0;
    bit watching    = 1'b0;

    function automatic bit ends_line(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

    // Keep only keywords whose character at pos equals c; past a keyword's end nothing matches.
    function automatic logic [KEYWORDS-1:0] narrow_live(input logic [KEYWORDS-1:0] live,
                                                        input int pos, input logic [7:0] c);
        logic [KEYWORDS-1:0] keep;
        keep = '0;
        for (int k = 0; k < KEYWORDS; k++)
        begin
            if (live[k] && pos < keyword_text[k].len() && 8'(keyword_text[k][pos]) == c)
            begin
                keep[k] = 1'b1;
            end
        end
        return keep;
    endfunction

    // Advance the predictor by one accepted byte; emits says whether a result beat follows.
    function automatic void recognise_byte(input logic [7:0] raw, output bit emits,
                                           output hdr_result_t r);
        logic [7:0] c;
        bit         found;
        c     = (raw >= 8'h61 && raw <= 8'h7A) ? raw - 8'h20 : raw;
        emits = 1'b0;
        found = 1'b0;
        r     = '{kind: KIND_CMD, command_index: 5'd0, arg_byte: 8'd0};
        case (lp_phase)
            LP_SKIP:
            begin
                // leading ':' / CR / LF are dropped; a leading space means an empty header
                if (c == CH_SPACE)
                begin
                    lp_phase = LP_DISCARD;
                end
                else if (c != CH_COLON && !ends_line(c))
                begin
                    live_set   = narrow_live('1, 0, c);
                    header_len = 4'd1;
                    lp_phase   = LP_HEADER;
                end
            end
            LP_HEADER:
            begin
                if (c == CH_COLON || c == CH_SPACE || ends_line(c))
                begin
                    emits = 1'b1;
                    // walk downwards so the lowest live entry is the last written
                    for (int k = KEYWORDS - 1; k >= 0; k--)
                    begin
                        if (live_set[k])
                        begin
                            found           = 1'b1;
                            r.command_index = 5'(k);
                        end
                    end
                    if (found)
                    begin
                        r.kind   = KIND_CMD;
                        lp_phase = ends_line(c) ? LP_SKIP : LP_ARGS;
                    end
                    else
                    begin
                        r.kind   = KIND_ERR;
                        lp_phase = ends_line(c) ? LP_SKIP : LP_DISCARD;
                    end
                    live_set   = '1;
                    header_len = 4'd0;
                end
                else
                begin
                    live_set = narrow_live(live_set, header_len, c);
                    if (header_len != 4'd15)
                    begin
                        header_len++;
                    end
                end
            end
            LP_ARGS:
            begin
                emits = 1'b1;
                if (ends_line(c))
                begin
                    r.kind   = KIND_EOL;
                    lp_phase = LP_SKIP;
                end
                else
                begin
                    r.kind     = KIND_ARG;
                    r.arg_byte = c;
                end
            end
            default:
            begin
                if (ends_line(c))
                begin
                    lp_phase = LP_SKIP;
                end
            end
        endcase
    endfunction

    // Present one byte from a falling edge, wait for its beat, book the expectation,
    // then maybe drop valid for a short burst. Returns on a falling edge.
    task automatic send_beat(input stim_row_t row);
        bit          emits;
        hdr_result_t r;
        cmd_if.in_byte = row.ch;
        cmd_if.valid   = 1'b1;
        @(posedge clk);
        while (!cmd_if.ready)
        begin
            @(posedge clk);
        end
        recognise_byte(row.ch, emits, r);
        case (row.check)
            CHECK_PREDICTED:
            begin
                if (emits)
                begin
                    pending_results.push_back(r);
                end
            end
            CHECK_TYPED:
            begin
                r = '{kind: row.kind, command_index: row.index, arg_byte: row.arg};
                pending_results.push_back(r);
            end
            default: ;
        endcase
        bytes_sent++;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            cmd_if.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
    endtask

    // Hold the sender off until every booked result beat has come back.
    task automatic wait_for_results();
        cmd_if.valid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Build one command line: mostly keyword prefixes in mixed case with arguments,
    // the rest long or random headers, empty headers and byte noise.
    task automatic send_random_line();
        logic [7:0] line [$];
        logic [7:0] ch;
        logic [7:0] stop;
        stim_row_t  row;
        int         pick;
        int         len;
        int         k;
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 2))
            begin
                case ($urandom_range(0, 2))
                    0:       line.push_back(CH_COLON);
                    1:       line.push_back(CH_CR);
                    default: line.push_back(CH_LF);
                endcase
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            k   = $urandom_range(0, KEYWORDS - 1);
            len = $urandom_range(1, keyword_text[k].len());
            for (int i = 0; i < len; i++)
            begin
                ch = 8'(keyword_text[k][i]);
                if (ch >= 8'h41 && ch <= 8'h5A && $urandom_range(0, 1) == 1)
                begin
                    ch = ch + 8'h20;
                end
                line.push_back(ch);
            end
        end
        else if (pick < 82)
        begin
            // letters only; lengths past 15 exercise the saturating header count
            len = $urandom_range(1, 20);
            repeat (len)
            begin
                ch = 8'($urandom_range(8'h41, 8'h5A)) | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
                line.push_back(ch);
            end
        end
        else if (pick < 88)
        begin
            line.push_back(CH_SPACE);
        end
        else
        begin
            repeat ($urandom_range(1, 10)) line.push_back(8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 3))
            0:       stop = CH_COLON;
            1:       stop = CH_SPACE;
            2:       stop = CH_CR;
            default: stop = CH_LF;
        endcase
        line.push_back(stop);
        if (!ends_line(stop))
        begin
            repeat ($urandom_range(0, 8))
            begin
                if ($urandom_range(0, 1) == 1)
                    line.push_back(8'($urandom_range(8'h20, 8'h7E)));
                else
                    line.push_back(8'($urandom_range(0, 255)));
            end
            line.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        end
        row.check = CHECK_PREDICTED;
        row.kind  = KIND_CMD;
        row.index = 5'd0;
        row.arg   = 8'd0;
        foreach (line[i])
        begin
            row.ch = line[i];
            send_beat(row);
        end
    endtask

    // Result side: ready changes on the falling edge, and new stalls start only while stalls_on is set.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            res_if.ready = 1'b0;
            stall_left--;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            res_if.ready = 1'b0;
            stall_left   = $urandom_range(0, 4);
        end
        else
        begin
            res_if.ready = 1'b1;
        end
    end

    // Scoreboard: every result beat against the oldest expectation, field by field.
    always @(posedge clk)
    begin
        hdr_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: kind %0d index %0d arg %02h",
                       res_if.kind, res_if.command_index, res_if.arg_byte);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_if.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, res_if.kind);
                    fail_count++;
                end
                if (res_if.command_index !== want.command_index)
                begin
                    $error("command_index: expected %0d, got %0d",
                           want.command_index, res_if.command_index);
                    fail_count++;
                end
                if (res_if.arg_byte !== want.arg_byte)
                begin
                    $error("arg_byte: expected %02h, got %02h", want.arg_byte, res_if.arg_byte);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long with no beat on either channel means the block has hung.
    always @(posedge clk)
    begin
        if (watching)
        begin
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("scpi_header_recognizer verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        // Directed lines: a keyword cut short, argument bytes at both extremes, an empty
        // header, a keyword prefix ended by space, an unknown header with its line thrown
        // away, and a header ended straight by CR.
        static stim_row_t directed_rows [25] = '{
            '{CH_COLON, CHECK_SILENT,    KIND_CMD, 5'd0,  8'h00},
            '{"g",      CHECK_PREDICTED, KIND_CMD, 5'd0,  8'h00},
            '{"o",      CHECK_PREDICTED, KIND_CMD, 5'd0,  8'h00},
            '{"v",      CHECK_PREDICTED, KIND_CMD, 5'd0,  8'h00},
            '{CH_COLON, CHECK_TYPED,     KIND_CMD, 5'd18, 8'h00},
            '{8'hFF,    CHECK_TYPED,     KIND_ARG, 5'd0,  8'hFF},
            '{8'h00,    CHECK_TYPED,     KIND_ARG, 5'd0,  8'h00},
            '{"a",      CHECK_PREDICTED, KIND_CMD, 5'd0,  8'h00},
            '{CH_COLON, CHECK_PREDICTED, KIND_CMD, 5'd0,  8'h00},
            '{CH_LF,    CHECK_TYPED,     KIND_EOL, 5'd0,  8'h00},
            '{CH_SPACE, CHECK_SILENT,    KIND_CMD, 5'd0,  8'h00},
            '{"k",      CHECK_SILENT,    KIND_CMD, 5'd0,  8'h00},
            '{CH_CR,    CHECK_SILENT,    KIND_CMD, 5'd0,  8'h00},
            '{"*",      CHECK_PREDICTED, KIND_CMD, 5'd0,  8'h00},
            '{"i",      CHECK_PREDICTED, KIND_CMD, 5'd0,  8'h00},
            '{"d",      CHECK_PREDICTED, KIND_CMD, 5'd0,  8'h00},
            '{"n",      CHECK_PREDICTED, KIND_CMD, 5'd0,  8'h00},
            '{CH_SPACE, CHECK_TYPED,     KIND_CMD, 5'd0,  8'h00},
            '{CH_CR,    CHECK_TYPED,     KIND_EOL, 5'd0,  8'h00},
            '{"X",      CHECK_PREDICTED, KIND_CMD, 5'd0,  8'h00},
            '{CH_COLON, CHECK_TYPED,     KIND_ERR, 5'd0,  8'h00},
            '{"y",      CHECK_SILENT,    KIND_CMD, 5'd0,  8'h00},
            '{CH_LF,    CHECK_SILENT,    KIND_CMD, 5'd0,  8'h00},
            '{"r",      CHECK_PREDICTED, KIND_CMD, 5'd0,  8'h00},
            '{CH_CR,    CHECK_PREDICTED, KIND_CMD, 5'd0,  8'h00}
        };

        cmd_if.valid   = 1'b0;
        cmd_if.in_byte = 8'h00;
        res_if.ready   = 1'b0;

        // single reset at the start, released on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n    = 1'b1;
        watching = 1'b1;

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        foreach (directed_rows[i])
        begin
            send_beat(directed_rows[i]);
        end

        // full drain between directed and random parts
        wait_for_results();

        // Random lines; idling switches on and off per line so some stretches run flat out,
        // and the tail runs with no idling at all.
        while (bytes_sent < ITEM_TARGET)
        begin
            if (bytes_sent > ITEM_TARGET - QUIET_TAIL)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            else
            begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            send_random_line();
            if ($urandom_range(0, 39) == 0)
            begin
                wait_for_results();
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("scpi_header_recognizer verification clean");
        else
            $display("scpi_header_recognizer verification failed");
        $finish;
    end

endmodule

`default_nettype wire
